// ===== design/quantized_delta_position_encoder_defines.svh =====
// Assertion macros for the quantized delta position encoder.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef QUANTIZED_DELTA_POSITION_ENCODER_DEFINES_SVH
`define QUANTIZED_DELTA_POSITION_ENCODER_DEFINES_SVH

// implication in the same cycle, masked during reset
`define QDPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, checked through reset
`define QDPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/qdpe_pkg.sv =====
// Shared types, register indexes and code kinds of the position encoder.
// No dependencies.
`timescale 1ns / 1ps
package qdpe_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIST_W     = 24;
  localparam int BITS_W     = 5;
  localparam int VAL_W      = 16;
  localparam int CNT_W      = 6;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 3;
  localparam int WORLD_HALF = 5000;
  localparam int WORLD_SPAN = 10000;

  localparam logic [IDX_W-1:0] REG_MIN_MOVE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_CUTOFF    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DBITS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_FBITS_INET = 3'd3;
  localparam logic [IDX_W-1:0] REG_FBITS_LAN = 3'd4;
  localparam logic [IDX_W-1:0] REG_INET_MODE = 3'd5;

  localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELTA     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL_MARK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL      = 2'd3;

  typedef struct packed {
    logic                         has_baseline;
    logic signed [COORD_BITS-1:0] src_x;
    logic signed [COORD_BITS-1:0] src_y;
    logic signed [COORD_BITS-1:0] src_z;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic signed [COORD_BITS-1:0] base_z;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0] code_kind;
    logic              sign_x;
    logic              sign_y;
    logic              sign_z;
    logic [VAL_W-1:0]  value_x;
    logic [VAL_W-1:0]  value_y;
    logic [VAL_W-1:0]  value_z;
    logic [CNT_W-1:0]  code_len;
  } out_t;

  typedef struct packed {
    logic [DIST_W-1:0] min_move;
    logic [DIST_W-1:0] cutoff;
    logic [BITS_W-1:0] delta_bits;
    logic [BITS_W-1:0] fbits_inet;
    logic [BITS_W-1:0] fbits_lan;
    logic              inet_mode;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [2:0]        neg;
    logic [CNT_W-1:0]  count;
  } side_t;

endpackage

// ===== design/qdpe_front.sv =====
// Front pipeline: axis deltas, move test, code kind, quantizer operands.
// Four stages; uses qdpe_pkg. Feeds qdpe_divider.
`timescale 1ns / 1ps
module qdpe_front #(
  parameter int FRAC_BITS      = 10,
  parameter int MAX_FIELD_BITS = 16,
  parameter int DW             = 24,
  parameter int QW             = 16,
  parameter int NW             = DW + QW + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qdpe_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qdpe_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0][NW-1:0]   out_num,
  output logic [DW:0]          out_den2,
  output qdpe_pkg::side_t      out_side
);
  import qdpe_pkg::*;

  localparam int     CB   = COORD_BITS;
  localparam int     MW   = CB + 1;
  localparam longint HALF = longint'(WORLD_HALF) << FRAC_BITS;
  localparam longint DEN  = longint'(WORLD_SPAN) << FRAC_BITS;
  localparam int     HB   = $clog2(HALF + 1);
  localparam int     SW   = ((CB > HB) ? CB : HB) + 2;
  localparam int     SQW  = 2 * DIST_W;
  localparam int     SUMW = SQW + 2;
  localparam logic [BITS_W-1:0] MAXB = BITS_W'(MAX_FIELD_BITS);

  function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b);
    logic [BITS_W-1:0] r;
    r = b;
    if (b == '0) r = BITS_W'(1);
    else if (b > MAXB) r = MAXB;
    return r;
  endfunction

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign rdy4      = !v4_r || out_ready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v4_r;

  // stage 1: deltas and offset positions
  logic signed [CB-1:0] src_c [3];
  logic signed [CB-1:0] base_c [3];
  logic signed [CB:0]   diff_c [3];
  logic [MW-1:0]        mag_c [3];
  logic signed [SW-1:0] s_c [3];

  assign src_c[0]  = in_data.src_x;
  assign src_c[1]  = in_data.src_y;
  assign src_c[2]  = in_data.src_z;
  assign base_c[0] = in_data.base_x;
  assign base_c[1] = in_data.base_y;
  assign base_c[2] = in_data.base_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = {src_c[i][CB-1], src_c[i]} - {base_c[i][CB-1], base_c[i]};
      mag_c[i]  = diff_c[i][CB] ? MW'(-diff_c[i]) : MW'(diff_c[i]);
      s_c[i]    = SW'(src_c[i]) + $signed(SW'(HALF));
    end
  end

  logic                 hb1_r;
  logic [2:0]           neg1_r;
  logic [MW-1:0]        mag1_r [3];
  logic signed [SW-1:0] s1_r [3];

  // stage 2: range tests, squares, clamped full operands
  logic              over_c, big_c;
  logic [DIST_W-1:0] mlo_c [3];
  logic [SQW-1:0]    sq_c [3];
  logic [SQW-1:0]    minsq_c;
  logic [DW-1:0]     af_c [3];

  always_comb begin
    over_c  = 1'b0;
    big_c   = 1'b0;
    minsq_c = SQW'(cfg.min_move) * SQW'(cfg.min_move);
    for (int i = 0; i < 3; i++) begin
      if (mag1_r[i] > MW'(cfg.cutoff)) over_c = 1'b1;
      if (mag1_r[i] > MW'(cfg.min_move)) big_c = 1'b1;
      mlo_c[i] = mag1_r[i][DIST_W-1:0];
      sq_c[i]  = SQW'(mlo_c[i]) * SQW'(mlo_c[i]);
      if (s1_r[i] <= $signed(SW'(0))) af_c[i] = '0;
      else if (s1_r[i] >= $signed(SW'(DEN))) af_c[i] = DW'(DEN);
      else af_c[i] = DW'(s1_r[i]);
    end
  end

  logic           hb2_r, over2_r, big2_r;
  logic [2:0]     neg2_r;
  logic [SQW-1:0] sq2_r [3];
  logic [SQW-1:0] minsq2_r;
  logic [DW-1:0]  ad2_r [3];
  logic [DW-1:0]  af2_r [3];

  // stage 3: move test and code kind
  logic [SUMW-1:0]   sum_c;
  logic              small_c;
  logic [KIND_W-1:0] kind_c;
  logic [BITS_W-1:0] db_c, fb_c, bsel_c;
  logic [QW:0]       one_sh_c;
  logic [QW-1:0]     maxv_c;
  logic [7:0]        cnt_c;
  logic [DW-1:0]     a_c [3];
  logic [DW-1:0]     d_c;
  side_t             side_c;

  always_comb begin
    sum_c   = SUMW'(sq2_r[0]) + SUMW'(sq2_r[1]) + SUMW'(sq2_r[2]);
    small_c = hb2_r && !big2_r && (sum_c <= SUMW'(minsq2_r));
    if (!hb2_r) kind_c = KIND_FULL;
    else if (small_c) kind_c = KIND_NONE;
    else if (!over2_r && cfg.inet_mode) kind_c = KIND_DELTA;
    else kind_c = KIND_FULL_MARK;
    db_c     = clamp_bits(cfg.delta_bits);
    fb_c     = clamp_bits(cfg.inet_mode ? cfg.fbits_inet : cfg.fbits_lan);
    bsel_c   = (kind_c == KIND_DELTA) ? db_c : fb_c;
    one_sh_c = (QW+1)'(1) << bsel_c;
    maxv_c   = QW'(one_sh_c - (QW+1)'(1));
    case (kind_c)
      KIND_DELTA:     cnt_c = 8'd1 + 8'd3 * (8'd1 + 8'(db_c));
      KIND_FULL_MARK: cnt_c = 8'd1 + 8'd3 * 8'(fb_c);
      KIND_FULL:      cnt_c = 8'd3 * 8'(fb_c);
      default:        cnt_c = 8'd0;
    endcase
    for (int i = 0; i < 3; i++) begin
      a_c[i] = (kind_c == KIND_DELTA) ? ad2_r[i] : af2_r[i];
    end
    if (kind_c == KIND_DELTA) d_c = (cfg.cutoff == '0) ? DW'(1) : DW'(cfg.cutoff);
    else d_c = DW'(DEN);
    side_c.kind  = kind_c;
    side_c.neg   = (kind_c == KIND_DELTA) ? neg2_r : 3'b000;
    side_c.count = CNT_W'(cnt_c);
  end

  side_t         side3_r;
  logic [DW-1:0] a3_r [3];
  logic [QW-1:0] maxv3_r;
  logic [DW-1:0] d3_r;

  // stage 4: scale by the field maximum
  logic [DW+QW-1:0] prod_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_c[i] = (DW+QW)'(a3_r[i]) * (DW+QW)'(maxv3_r);
    end
  end

  side_t            side4_r;
  logic [DW+QW-1:0] prod4_r [3];
  logic [DW-1:0]    d4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      hb1_r <= in_data.has_baseline;
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= diff_c[i][CB];
        mag1_r[i] <= mag_c[i];
        s1_r[i]   <= s_c[i];
      end
    end
    if (rdy2 && v1_r) begin
      hb2_r    <= hb1_r;
      over2_r  <= over_c;
      big2_r   <= big_c;
      neg2_r   <= neg1_r;
      minsq2_r <= minsq_c;
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= sq_c[i];
        ad2_r[i] <= DW'(mag1_r[i]);
        af2_r[i] <= af_c[i];
      end
    end
    if (rdy3 && v2_r) begin
      side3_r <= side_c;
      maxv3_r <= maxv_c;
      d3_r    <= d_c;
      for (int i = 0; i < 3; i++) a3_r[i] <= a_c[i];
    end
    if (rdy4 && v3_r) begin
      side4_r <= side3_r;
      d4_r    <= d3_r;
      for (int i = 0; i < 3; i++) prod4_r[i] <= prod_c[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_num[i] = NW'({prod4_r[i], 1'b0}) + NW'(d4_r);
    end
  end

  assign out_den2 = {d4_r, 1'b0};
  assign out_side = side4_r;

endmodule

// ===== design/qdpe_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// Lanes share a divisor per beat; uses qdpe_pkg for the sideband type.
`timescale 1ns / 1ps
module qdpe_divider #(
  parameter int DW = 24,
  parameter int QW = 16,
  parameter int NW = DW + QW + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0][NW-1:0] in_num,
  input  logic [DW:0]        in_den2,
  input  qdpe_pkg::side_t    in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0][QW-1:0] out_quot,
  output qdpe_pkg::side_t    out_side
);
  import qdpe_pkg::*;

  logic [QW-1:0] v_r;
  logic [DW:0]   rem_r [QW][3];
  logic [QW-1:0] qr_r [QW][3];
  logic [DW:0]   den_r [QW];
  side_t         side_r [QW];

  logic [QW:0]   nrdy;
  logic [QW-1:0] vin;
  logic [DW:0]   rem_i [QW][3];
  logic [QW-1:0] qr_i [QW][3];
  logic [DW:0]   den_i [QW];
  side_t         side_i [QW];
  logic [DW+1:0] trial [QW][3];
  logic          ge [QW][3];
  logic [DW:0]   rem_n [QW][3];
  logic [QW-1:0] qr_n [QW][3];

  always_comb begin
    nrdy[QW] = out_ready;
    for (int k = QW - 1; k >= 0; k--) nrdy[k] = !v_r[k] || nrdy[k+1];
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        vin[k]    = in_valid;
        den_i[k]  = in_den2;
        side_i[k] = in_side;
        for (int l = 0; l < 3; l++) begin
          rem_i[k][l] = in_num[l][NW-1:QW];
          qr_i[k][l]  = in_num[l][QW-1:0];
        end
      end else begin
        vin[k]    = v_r[k-1];
        den_i[k]  = den_r[k-1];
        side_i[k] = side_r[k-1];
        for (int l = 0; l < 3; l++) begin
          rem_i[k][l] = rem_r[k-1][l];
          qr_i[k][l]  = qr_r[k-1][l];
        end
      end
      for (int l = 0; l < 3; l++) begin
        trial[k][l] = {rem_i[k][l], qr_i[k][l][QW-1]};
        ge[k][l]    = trial[k][l] >= {1'b0, den_i[k]};
        rem_n[k][l] = ge[k][l] ? (DW+1)'(trial[k][l] - {1'b0, den_i[k]})
                               : trial[k][l][DW:0];
        qr_n[k][l]  = {qr_i[k][l][QW-2:0], ge[k][l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < QW; k++) begin
        if (nrdy[k]) v_r[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (nrdy[k] && vin[k]) begin
        den_r[k]  <= den_i[k];
        side_r[k] <= side_i[k];
        for (int l = 0; l < 3; l++) begin
          rem_r[k][l] <= rem_n[k][l];
          qr_r[k][l]  <= qr_n[k][l];
        end
      end
    end
  end

  assign in_ready  = nrdy[0];
  assign out_valid = v_r[QW-1];
  assign out_side  = side_r[QW-1];
  always_comb begin
    for (int l = 0; l < 3; l++) out_quot[l] = qr_r[QW-1][l];
  end

endmodule

// ===== design/quantized_delta_position_encoder.sv =====
// Path: the qdpe_front stages, then the qdpe_divider stages, from input beat to result beat.
// Throughput: one beat per cycle unless out_ready stalls the pipeline; the divider gives one quotient bit per stage.
// Each stage holds its beat under backpressure and takes a new one once free.
// Reset: synchronous active-low rst_n empties the pipeline and loads register defaults.
// Uses qdpe_pkg, qdpe_front, qdpe_divider and the defines header.
`timescale 1ns / 1ps
`include "quantized_delta_position_encoder_defines.svh"
module quantized_delta_position_encoder #(
  parameter int FRAC_BITS      = 10,
  parameter int MAX_FIELD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  qdpe_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output qdpe_pkg::out_t               out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [qdpe_pkg::IDX_W-1:0]   cfg_index,
  input  logic [qdpe_pkg::DIST_W-1:0]  cfg_data
);
  import qdpe_pkg::*;

  localparam longint DEN  = longint'(WORLD_SPAN) << FRAC_BITS;
  localparam int     DENB = $clog2(DEN + 1);
  localparam int     DW   = (DENB > DIST_W) ? DENB : DIST_W;
  localparam int     QW   = MAX_FIELD_BITS;
  localparam int     NW   = DW + QW + 1;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_move   <= '0;
      cfg_r.cutoff     <= DIST_W'(10240);
      cfg_r.delta_bits <= BITS_W'(8);
      cfg_r.fbits_inet <= BITS_W'(16);
      cfg_r.fbits_lan  <= BITS_W'(16);
      cfg_r.inet_mode  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_MOVE:   cfg_r.min_move   <= cfg_data;
        REG_CUTOFF:     cfg_r.cutoff     <= cfg_data;
        REG_DBITS:      cfg_r.delta_bits <= cfg_data[BITS_W-1:0];
        REG_FBITS_INET: cfg_r.fbits_inet <= cfg_data[BITS_W-1:0];
        REG_FBITS_LAN:  cfg_r.fbits_lan  <= cfg_data[BITS_W-1:0];
        REG_INET_MODE:  cfg_r.inet_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic               fr_valid, fr_ready;
  logic [2:0][NW-1:0] fr_num;
  logic [DW:0]        fr_den2;
  side_t              fr_side;
  logic [2:0][QW-1:0] dv_quot;
  side_t              dv_side;

  qdpe_front #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .DW             (DW),
    .QW             (QW),
    .NW             (NW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_num   (fr_num),
    .out_den2  (fr_den2),
    .out_side  (fr_side)
  );

  qdpe_divider #(
    .DW (DW),
    .QW (QW),
    .NW (NW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_num    (fr_num),
    .in_den2   (fr_den2),
    .in_side   (fr_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  logic none_c;

  assign none_c = (dv_side.kind == KIND_NONE);

  always_comb begin
    out_data.code_kind = dv_side.kind;
    out_data.sign_x    = dv_side.neg[0];
    out_data.sign_y    = dv_side.neg[1];
    out_data.sign_z    = dv_side.neg[2];
    out_data.value_x   = none_c ? '0 : VAL_W'(dv_quot[0]);
    out_data.value_y   = none_c ? '0 : VAL_W'(dv_quot[1]);
    out_data.value_z   = none_c ? '0 : VAL_W'(dv_quot[2]);
    out_data.code_len  = dv_side.count;
  end

  logic is_none_c, is_full_c, vals_zero_c, signs_zero_c;

  assign is_none_c    = (out_data.code_kind == KIND_NONE);
  assign is_full_c    = (out_data.code_kind == KIND_FULL) ||
                        (out_data.code_kind == KIND_FULL_MARK);
  assign vals_zero_c  = (out_data.code_len == '0) && (out_data.value_x == '0) &&
                        (out_data.value_y == '0) && (out_data.value_z == '0);
  assign signs_zero_c = !out_data.sign_x && !out_data.sign_y && !out_data.sign_z;

  `QDPE_ASSERT_NXT(a_reset_empty, !rst_n, !out_valid, "result beat right after reset")
  `QDPE_ASSERT_IMP(a_none_zero, out_valid && is_none_c, vals_zero_c, "empty code carries data")
  `QDPE_ASSERT_IMP(a_full_nosign, out_valid && is_full_c, signs_zero_c, "full code carries a sign")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the quantized delta position encoder.
// Drives random and corner positions through directed and random configurations and checks every code word.
// Depends on qdpe_pkg and the quantized_delta_position_encoder top level.
`timescale 1ns / 1ps
module testbench;
  import qdpe_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int MAXF = 16;

  class code_scoreboard;
    out_t        code_q[$];
    int          mismatches;
    int          checked;
    int          kind_seen[4];
    logic [23:0] min_move;
    logic [23:0] cutoff;
    logic [4:0]  dbits;
    logic [4:0]  fbits_inet;
    logic [4:0]  fbits_lan;
    logic        inet;

    function void reset_regs();
      min_move = 24'd0;
      cutoff = 24'd10240;
      dbits = 5'd8;
      fbits_inet = 5'd16;
      fbits_lan = 5'd16;
      inet = 1'b1;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [23:0] v);
      case (idx)
        REG_MIN_MOVE:   min_move = v;
        REG_CUTOFF:     cutoff = v;
        REG_DBITS:      dbits = v[4:0];
        REG_FBITS_INET: fbits_inet = v[4:0];
        REG_FBITS_LAN:  fbits_lan = v[4:0];
        REG_INET_MODE:  inet = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_bits(int unsigned b);
      if (b < 1) return 1;
      if (b > MAXF) return MAXF;
      return b;
    endfunction

    function longint unsigned full_code(longint p, longint unsigned maxv);
      longint unsigned den;
      longint s;
      longint unsigned q;
      den = 64'd10000 << 10;
      s = p + (64'sd5000 <<< 10);
      if (s <= 0) return 64'd0;
      q = (64'd2 * longint'(s) * maxv + den) / (64'd2 * den);
      return (q > maxv) ? maxv : q;
    endfunction

    function out_t encode(in_t d);
      longint src[3];
      longint bas[3];
      longint dl;
      longint unsigned mag[3];
      longint unsigned sq, minv, maxv, cut, q;
      int unsigned b, f;
      bit short_move, over;
      out_t r;
      logic [15:0] v[3];
      logic [2:0] sg;
      logic [1:0] kind;
      int cnt;
      src[0] = longint'(d.src_x); src[1] = longint'(d.src_y); src[2] = longint'(d.src_z);
      bas[0] = longint'(d.base_x); bas[1] = longint'(d.base_y); bas[2] = longint'(d.base_z);
      v[0] = 16'd0; v[1] = 16'd0; v[2] = 16'd0;
      sg = 3'b000;
      cnt = 0;
      kind = d.has_baseline ? KIND_FULL_MARK : KIND_FULL;
      if (d.has_baseline) begin
        minv = 64'(min_move);
        short_move = 1;
        over = 0;
        for (int i = 0; i < 3; i++) begin
          dl = src[i] - bas[i];
          mag[i] = (dl < 0) ? -dl : dl;
          sg[i] = (dl < 0);
          if (mag[i] > minv) short_move = 0;
          if (mag[i] > 64'(cutoff)) over = 1;
        end
        if (short_move) begin
          sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
          short_move = sq <= minv * minv;
        end
        if (short_move) begin
          kind = KIND_NONE;
          sg = 3'b000;
        end else if (!over && inet) begin
          b = clamp_bits(32'(dbits));
          maxv = (64'd1 << b) - 1;
          cut = (cutoff == 24'd0) ? 64'd1 : 64'(cutoff);
          kind = KIND_DELTA;
          for (int i = 0; i < 3; i++) begin
            q = (64'd2 * mag[i] * maxv + cut) / (64'd2 * cut);
            v[i] = 16'((q > maxv) ? maxv : q);
          end
          cnt = 1 + 3 * (1 + int'(b));
        end else begin
          sg = 3'b000;
        end
      end
      if (kind == KIND_FULL_MARK || kind == KIND_FULL) begin
        f = clamp_bits(32'(inet ? fbits_inet : fbits_lan));
        maxv = (64'd1 << f) - 1;
        for (int i = 0; i < 3; i++) v[i] = 16'(full_code(src[i], maxv));
        cnt = (kind == KIND_FULL_MARK ? 1 : 0) + 3 * int'(f);
      end
      r.code_kind = kind;
      r.sign_x = sg[0];
      r.sign_y = sg[1];
      r.sign_z = sg[2];
      r.value_x = v[0];
      r.value_y = v[1];
      r.value_z = v[2];
      r.code_len = 6'(cnt);
      return r;
    endfunction

    function void note_input(in_t d);
      code_q.push_back(encode(d));
    endfunction

    function void report(string what, out_t e, out_t a);
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch %0s: exp kind=%0d s=%b%b%b v=%h/%h/%h n=%0d",
                  "  act kind=%0d s=%b%b%b v=%h/%h/%h n=%0d"},
                 what, e.code_kind, e.sign_x, e.sign_y, e.sign_z, e.value_x, e.value_y,
                 e.value_z, e.code_len, a.code_kind, a.sign_x, a.sign_y, a.sign_z,
                 a.value_x, a.value_y, a.value_z, a.code_len);
    endfunction

    function void check_code(out_t a);
      out_t e;
      if (code_q.size() == 0) begin
        e = '0;
        report("unexpected beat", e, a);
        return;
      end
      e = code_q.pop_front();
      checked++;
      kind_seen[e.code_kind]++;
      if (a.code_kind !== e.code_kind || a.sign_x !== e.sign_x || a.sign_y !== e.sign_y ||
          a.sign_z !== e.sign_z || a.value_x !== e.value_x || a.value_y !== e.value_y ||
          a.value_z !== e.value_z || a.code_len !== e.code_len)
        report("field", e, a);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_t  in_data;
  out_t out_data;
  logic [IDX_W-1:0]  cfg_index;
  logic [DIST_W-1:0] cfg_data;

  code_scoreboard sb;
  bit send_gaps;
  bit recv_gaps;
  int hold_cycles;

  quantized_delta_position_encoder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_code(out_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_pos(in_t d);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_cfg(logic [IDX_W-1:0] idx, logic [DIST_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.code_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [23:0] bits_word(int unsigned b);
    return {19'($urandom_range(0, 524287)), b[4:0]};
  endfunction

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      2: return $urandom_range(0, 1) ? 24'sd5120000 : -24'sd5120000;
      default: return $signed(24'($urandom_range(0, 10240000))) - 24'sd5120000;
    endcase
  endfunction

  function automatic in_t rand_pos();
    in_t d;
    int span;
    d.has_baseline = $urandom_range(0, 4) != 0;
    d.base_x = rand_coord();
    d.base_y = rand_coord();
    d.base_z = rand_coord();
    if ($urandom_range(0, 9) < 7) begin
      span = (sb.cutoff > 24'd1000000) ? 1000000 : int'(sb.cutoff) + 2;
      d.src_x = d.base_x + 24'($urandom_range(0, 2 * span) - span);
      d.src_y = d.base_y + 24'($urandom_range(0, 2 * span) - span);
      d.src_z = d.base_z + 24'($urandom_range(0, 2 * span) - span);
    end else begin
      d.src_x = rand_coord();
      d.src_y = rand_coord();
      d.src_z = rand_coord();
    end
    return d;
  endfunction

  function automatic in_t mk(logic hb, int sx, int sy, int sz, int bx, int by, int bz);
    in_t d;
    d.has_baseline = hb;
    d.src_x = 24'(sx); d.src_y = 24'(sy); d.src_z = 24'(sz);
    d.base_x = 24'(bx); d.base_y = 24'(by); d.base_z = 24'(bz);
    return d;
  endfunction

  task automatic random_config();
    write_cfg(REG_CUTOFF, $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                    : 24'($urandom_range(1, 40000)));
    write_cfg(REG_MIN_MOVE, $urandom_range(0, 2) == 0 ? 24'd0
                                                      : 24'($urandom_range(0, sb.cutoff)));
    write_cfg(REG_DBITS, bits_word($urandom_range(0, 31)));
    write_cfg(REG_FBITS_INET, bits_word($urandom_range(0, 31)));
    write_cfg(REG_FBITS_LAN, bits_word($urandom_range(0, 31)));
    write_cfg(REG_INET_MODE, {23'($urandom_range(0, 8388607)),
                              $urandom_range(0, 4) != 0 ? 1'b1 : 1'b0});
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    hold_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners under the default settings
    send_pos(mk(0, 0, 0, 0, 0, 0, 0));
    send_pos(mk(0, 8388607, -8388608, 5120000, 0, 0, 0));
    send_pos(mk(0, -5120000, -5120001, 5120001, 0, 0, 0));
    send_pos(mk(0, -5119999, 5119999, 1, 0, 0, 0));
    send_pos(mk(1, 100, -200, 300, 100, -200, 300));
    send_pos(mk(1, 10240, -10240, 0, 0, 0, 0));
    send_pos(mk(1, 5, -7, 0, 0, 0, 0));
    send_pos(mk(1, 10241, 0, 0, 0, 0, 0));
    send_pos(mk(1, 8388607, 0, 0, -8388608, 0, 0));
    send_pos(mk(1, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_pos(mk(1, 20, 20, 20, 40, 0, 20));
    drain();
    write_cfg(REG_MIN_MOVE, 24'd100);
    write_cfg(REG_INET_MODE, 24'd0);
    write_cfg(REG_FBITS_LAN, 24'd1);
    write_cfg(REG_UNUSED, 24'hFFFFFF);
    send_pos(mk(1, 100, 0, 0, 0, 0, 0));
    send_pos(mk(1, 60, 60, 60, 0, 0, 0));
    send_pos(mk(1, 101, 0, 0, 0, 0, 0));
    send_pos(mk(0, 5120000, -5120000, 0, 0, 0, 0));
    drain();
    write_cfg(REG_INET_MODE, 24'd1);
    write_cfg(REG_CUTOFF, 24'd0);
    write_cfg(REG_DBITS, 24'd0);
    write_cfg(REG_FBITS_INET, 24'd31);
    send_pos(mk(1, 0, 0, 0, 0, 0, 0));
    send_pos(mk(1, 1, 0, 0, 0, 0, 0));
    send_pos(mk(1, 3000, 0, 0, 0, 0, 0));
    drain();
    write_cfg(REG_MIN_MOVE, 24'hFFFFFF);
    write_cfg(REG_CUTOFF, 24'hFFFFFF);
    write_cfg(REG_DBITS, 24'd31);
    write_cfg(REG_FBITS_INET, 24'd0);
    send_pos(mk(1, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
    send_pos(mk(1, 8388607, 0, 0, 0, 0, 0));
    send_pos(mk(1, -1000000, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_cfg(REG_MIN_MOVE, 24'd0);
        write_cfg(REG_CUTOFF, 24'd1);
        write_cfg(REG_DBITS, 24'd16);
        write_cfg(REG_FBITS_INET, 24'd16);
      end else begin
        random_config();
      end
      if (ph == 7) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
      if (ph == 2) hold_cycles = 300;
      repeat (115) send_pos(rand_pos());
      drain();
    end

    $display("checked %0d code words: %0d empty, %0d delta, %0d full marked, %0d full plain",
             sb.checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
    $display("register settings covered bit widths 0..31, cutoffs 0..max and both modes");
    if (sb.mismatches == 0 && sb.code_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d code words missing", sb.mismatches, sb.code_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
